@@ hw/rtl/pal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Request and response structs, entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned PosW         = 7;
  localparam int unsigned LenW         = 7;
  localparam int unsigned CodeW        = 16;
  localparam int unsigned PayW         = 64;
  localparam int unsigned StatW        = 2;

  localparam logic [ModeW-1:0] ModeClear  = 3'd0;
  localparam logic [ModeW-1:0] ModeGet    = 3'd1;
  localparam logic [ModeW-1:0] ModeInsert = 3'd2;
  localparam logic [ModeW-1:0] ModeDelete = 3'd3;
  localparam logic [ModeW-1:0] ModeDump   = 3'd4;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatBadPos = 2'd1;
  localparam logic [StatW-1:0] StatFull   = 2'd2;
  localparam logic [StatW-1:0] StatEmpty  = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PosW-1:0]  position;
    logic [CodeW-1:0] entry_code;
    logic [PayW-1:0]  entry_payload;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [LenW-1:0]  list_length;
    logic [PosW-1:0]  out_position;
    logic [CodeW-1:0] out_code;
    logic [PayW-1:0]  out_payload;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [PayW-1:0]  payload;
  } entry_t;

endpackage

@@ hw/rtl/pal_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ram: entry memory of the positional array list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int unsigned DEPTH = pal_pkg::DepthDefault,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  pal_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output pal_pkg::entry_t  rdata_o
);
  import pal_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/positional_array_list_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit: packed ordered list with one-based positions
// Clear, get, insert, delete and dump over an entry memory of DEPTH words.
// ----------------------------------------------------------------------------
// channel    direction  handshake                 payload
// request    in         start && !busy            req_i  (pal_pkg::req_t)
// response   out        rsp_valid_o, one cycle    rsp_o  (pal_pkg::rsp_t)
//
// clear, unused modes, failed checks and appends answer in the cycle after
// the transfer; get reads the entry and answers from state SGet; insert
// and delete move one entry per cycle through the single read and write
// port; dump gives one result per cycle.
// reset clears the state, the entry count and the response valid; the memory needs no clearing pass.
// results cannot be stalled; busy stays high until the last one is issued.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
  parameter int unsigned DEPTH = pal_pkg::DepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pal_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output pal_pkg::rsp_t rsp_o
);
  import pal_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW + 1 > PosW) ? CntW + 1 : PosW;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SGet    = 3'd1;
  localparam logic [2:0] SIns    = 3'd2;
  localparam logic [2:0] SInsFin = 3'd3;
  localparam logic [2:0] SDel    = 3'd4;
  localparam logic [2:0] SDump   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] pa_q, pa_d;
  logic [PosW-1:0] pos_q, pos_d;
  entry_t          ent_q, ent_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic            ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            pos_in_list, pos_in_ins, list_full;
  logic [AddrW-1:0] req_addr, last_idx;
  logic [CntW-1:0] dump_pos;

  pal_ram #(
    .DEPTH (DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pos_ext     = CmpW'(req_i.position);
  assign cnt_ext     = CmpW'(count_q);
  assign pos_in_list = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_in_ins  = (pos_ext != '0) && (pos_ext <= cnt_ext + CmpW'(1));
  assign list_full   = (count_q == CntW'(DEPTH));
  assign req_addr    = AddrW'(pos_ext - CmpW'(1));
  assign last_idx    = AddrW'(count_q - CntW'(1));
  assign dump_pos    = CntW'(k_q) + CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    pa_d        = pa_q;
    pos_d       = pos_q;
    ent_d       = ent_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    rsp_d.last  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ent_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      SIdle: begin
        if (start) begin
          pos_d         = req_i.position;
          pa_d          = req_addr;
          ent_d.code    = req_i.entry_code;
          ent_d.payload = req_i.entry_payload;
          unique case (req_i.mode)
            ModeClear: begin
              count_d     = '0;
              rsp_valid_d = 1'b1;
            end
            ModeGet: begin
              if (count_q == '0) begin
                rsp_d.status = StatEmpty;
                rsp_valid_d  = 1'b1;
              end else if (!pos_in_list) begin
                rsp_d.status = StatBadPos;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = req_addr;
                state_d   = SGet;
              end
            end
            ModeInsert: begin
              if (list_full) begin
                rsp_d.status = StatFull;
                rsp_valid_d  = 1'b1;
              end else if (!pos_in_ins) begin
                rsp_d.status = StatBadPos;
                rsp_valid_d  = 1'b1;
              end else if (pos_ext == cnt_ext + CmpW'(1)) begin
                // append at the tail, nothing to shift
                ram_we             = 1'b1;
                ram_waddr          = req_addr;
                ram_wdata.code     = req_i.entry_code;
                ram_wdata.payload  = req_i.entry_payload;
                count_d            = count_q + CntW'(1);
                rsp_d.out_position = req_i.position;
                rsp_d.out_code     = req_i.entry_code;
                rsp_d.out_payload  = req_i.entry_payload;
                rsp_valid_d        = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                k_d       = last_idx;
                state_d   = SIns;
              end
            end
            ModeDelete: begin
              if (count_q == '0) begin
                rsp_d.status = StatEmpty;
                rsp_valid_d  = 1'b1;
              end else if (!pos_in_list) begin
                rsp_d.status = StatBadPos;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = req_addr;
                k_d       = req_addr;
                state_d   = SDel;
              end
            end
            ModeDump: begin
              if (count_q == '0) begin
                rsp_d.status = StatEmpty;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                k_d       = '0;
                state_d   = SDump;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      SGet: begin
        rsp_d.out_position = pos_q;
        rsp_d.out_code     = ram_rdata.code;
        rsp_d.out_payload  = ram_rdata.payload;
        rsp_valid_d        = 1'b1;
        state_d            = SIdle;
      end

      SIns: begin
        // move the entry just read one place up, walking toward the head
        ram_we    = 1'b1;
        ram_waddr = k_q + AddrW'(1);
        ram_wdata = ram_rdata;
        if (k_q == pa_q) begin
          state_d = SInsFin;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_q - AddrW'(1);
          k_d       = k_q - AddrW'(1);
        end
      end

      SInsFin: begin
        ram_we             = 1'b1;
        ram_waddr          = pa_q;
        ram_wdata          = ent_q;
        count_d            = count_q + CntW'(1);
        rsp_d.out_position = pos_q;
        rsp_d.out_code     = ent_q.code;
        rsp_d.out_payload  = ent_q.payload;
        rsp_valid_d        = 1'b1;
        state_d            = SIdle;
      end

      SDel: begin
        // first read is the removed entry, later ones move one place down
        if (k_q == pa_q) begin
          ent_d = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = k_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        if (k_q == last_idx) begin
          count_d            = count_q - CntW'(1);
          rsp_d.out_position = pos_q;
          rsp_d.out_code     = (k_q == pa_q) ? ram_rdata.code : ent_q.code;
          rsp_d.out_payload  = (k_q == pa_q) ? ram_rdata.payload : ent_q.payload;
          rsp_valid_d        = 1'b1;
          state_d            = SIdle;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_q + AddrW'(1);
          k_d       = k_q + AddrW'(1);
        end
      end

      SDump: begin
        rsp_d.out_position = PosW'(dump_pos);
        rsp_d.out_code     = ram_rdata.code;
        rsp_d.out_payload  = ram_rdata.payload;
        rsp_d.last         = (k_q == last_idx);
        rsp_valid_d        = 1'b1;
        if (k_q == last_idx) begin
          state_d = SIdle;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_q + AddrW'(1);
          k_d       = k_q + AddrW'(1);
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase

    rsp_d.list_length = LenW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    pa_q  <= pa_d;
    pos_q <= pos_d;
    ent_q <= ent_d;
    rsp_q <= rsp_d;
  end

  assign busy        = (state_q != SIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_dump_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.last) |=> rsp_valid_o)
    else $error("dump stream broken before last");

  a_transfer_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_valid_o))
    else $error("accepted request produced no work");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write to the same entry in one cycle");
`endif

endmodule
